### rtl/send_window_ack_tracker_defines.svh
// Assertion helpers for the send window tracker.
`ifndef SEND_WINDOW_ACK_TRACKER_DEFINES_SVH
`define SEND_WINDOW_ACK_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWAT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SWAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/swat_pkg.sv
package swat_pkg;

   // Window depth default and threshold reset
   localparam int unsigned WINDOW_DEPTH_DEFAULT = 16;
   localparam int unsigned THR_W                = 3;
   localparam logic [THR_W-1:0] DUP_THR_RESET   = 3'd3;

   // Field widths
   localparam int unsigned SEQ_W  = 32;
   localparam int unsigned FUNC_W = 1;
   localparam int unsigned SLOT_W = 5;
   localparam int unsigned RSP_W  = 16;

   // Request kinds
   localparam logic FUNC_SEND = 1'b0;
   localparam logic FUNC_ACK  = 1'b1;

   // Result beat bit positions
   localparam int unsigned RSP_ACCEPTED_BIT = 0;
   localparam int unsigned RSP_FREE_LSB     = 1;
   localparam int unsigned RSP_REL_LSB      = 6;
   localparam int unsigned RSP_FAST_BIT     = 11;
   localparam int unsigned RSP_STOP_BIT     = 12;
   localparam int unsigned RSP_START_BIT    = 13;
   localparam int unsigned RSP_EMPTIED_BIT  = 14;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;    // capture request beat
      logic commit;  // apply item, load result register
   } swat_cmd_type;

endpackage

### rtl/swat_ctrl.sv
module swat_ctrl import swat_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output swat_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // commit once the result register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/swat_dp.sv
module swat_dp import swat_pkg::*; #(
   parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  swat_cmd_type     cmd,
   input  logic             req_func,
   input  logic [SEQ_W-1:0] req_seq,
   input  logic             csr_wen,
   input  logic [THR_W-1:0] csr_wdata,
   output logic [RSP_W-1:0] rsp_data
);

   localparam int unsigned PTR_W = $clog2(WINDOW_DEPTH);
   localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;
   localparam int unsigned EXT_W = CNT_W + SLOT_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(WINDOW_DEPTH);

   // Circular window storage: head points at the oldest entry
   logic [SEQ_W-1:0] win_ff [WINDOW_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [SEQ_W-1:0] last_ack_ff, last_ack_in;
   logic [THR_W-1:0] dup_ff, dup_in, dup_inc;
   logic [THR_W-1:0] thr_ff;

   // Captured request
   logic             func_ff;
   logic [SEQ_W-1:0] seq_ff;

   // Search
   logic [WINDOW_DEPTH-1:0] match;
   logic [WINDOW_DEPTH-1:0] rot;
   logic [CNT_W-1:0]        hit;
   logic [PTR_W-1:0]        tail;

   // Result fields
   logic             accepted, fast, stop, start, emptied;
   logic [CNT_W-1:0] released, free_full;
   logic [EXT_W-1:0] free_ext, rel_ext;
   logic [RSP_W-1:0] rsp_in, rsp_ff;
   logic             do_write;

   // Reduce a pointer sum below the depth (sum stays under twice the depth)
   function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0] r;
      r = (v >= DEPTH_SUM) ? (v - DEPTH_SUM) : v;
      return r[PTR_W-1:0];
   endfunction

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         seq_ff  <= req_seq;
      end
   end

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= DUP_THR_RESET;
      end else if (csr_wen) begin
         thr_ff <= csr_wdata;
      end
   end

   // Parallel compare, rotated into age order, then first hit in window
   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         match[i] = (win_ff[i] == seq_ff);
      end
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         rot[k] = match[wrap_ptr(SUM_W'(head_ff) + SUM_W'(k))];
      end
      hit = occ_ff;
      for (int k = WINDOW_DEPTH - 1; k >= 0; k--) begin
         if (rot[k] && (CNT_W'(k) < occ_ff)) begin
            hit = CNT_W'(k);
         end
      end
   end

   assign tail = wrap_ptr(SUM_W'(head_ff) + SUM_W'(occ_ff));

   // Item update
   always_comb begin
      head_in     = head_ff;
      occ_in      = occ_ff;
      last_ack_in = last_ack_ff;
      dup_in      = dup_ff;
      dup_inc     = dup_ff + 1'b1;
      accepted    = 1'b1;
      fast        = 1'b0;
      stop        = 1'b0;
      start       = 1'b0;
      emptied     = 1'b0;
      released    = '0;
      do_write    = 1'b0;
      if (func_ff == FUNC_SEND) begin
         if (occ_ff < DEPTH_CNT) begin
            do_write = 1'b1;
            occ_in   = occ_ff + 1'b1;
         end else begin
            accepted = 1'b0;
         end
      end else begin
         // duplicate ack counting
         if (seq_ff != last_ack_ff) begin
            last_ack_in = seq_ff;
            dup_in      = '0;
         end else if (dup_inc == thr_ff) begin
            dup_in = '0;
            fast   = 1'b1;
            stop   = 1'b1;
         end else begin
            dup_in = dup_inc;
         end
         // cumulative release
         if (hit != '0) begin
            stop     = 1'b1;
            released = hit;
            head_in  = wrap_ptr(SUM_W'(head_ff) + SUM_W'(hit));
            occ_in   = occ_ff - hit;
            start    = (occ_in != '0);
            emptied  = (occ_in == '0);
         end
      end
   end

   // Pack result beat
   always_comb begin
      free_full = DEPTH_CNT - occ_in;
      free_ext  = EXT_W'(free_full);
      rel_ext   = EXT_W'(released);
      rsp_in    = '0;
      rsp_in[RSP_ACCEPTED_BIT]               = accepted;
      rsp_in[RSP_FREE_LSB +: SLOT_W]         = free_ext[SLOT_W-1:0];
      rsp_in[RSP_REL_LSB +: SLOT_W]          = rel_ext[SLOT_W-1:0];
      rsp_in[RSP_FAST_BIT]                   = fast;
      rsp_in[RSP_STOP_BIT]                   = stop;
      rsp_in[RSP_START_BIT]                  = start;
      rsp_in[RSP_EMPTIED_BIT]                = emptied;
   end

   // Window write at tail
   always_ff @(posedge clock) begin
      if (cmd.commit && do_write) begin
         win_ff[tail] <= seq_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         occ_ff      <= '0;
         last_ack_ff <= '0;
         dup_ff      <= '0;
      end else if (cmd.commit) begin
         head_ff     <= head_in;
         occ_ff      <= occ_in;
         last_ack_ff <= last_ack_in;
         dup_ff      <= dup_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### rtl/send_window_ack_tracker.sv
// A request beat is captured, then searched and committed into the result register;
// no new request beat is taken until that commit, which is held back
//   while a held result beat waits on rsp_tready.
// Reset: clears occupancy, last ack and duplicate count, loads threshold 3;
//   window storage is not cleared and is only read below occupancy.
`include "send_window_ack_tracker_defines.svh"

module send_window_ack_tracker import swat_pkg::*; #(
   parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [SEQ_W-1:0] req_tdata,  // [31:0] seq_num
   input  logic             req_tuser,  // [0] func
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [0] accepted, [5:1] free_slots, [10:6] slots_released, [11] fast_retransmit,
   // [12] stop_timer, [13] start_timer, [14] window_emptied, [15] zero
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_wen,
   input  logic [THR_W-1:0] csr_wdata  // dup_ack_threshold
);

   swat_cmd_type cmd;

   swat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   swat_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_func  (req_tuser),
      .req_seq   (req_tdata),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_tdata)
   );

   // One item in flight: no second request beat right after one is taken
   `SWAT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   // A refused send only happens on a full window
   `SWAT_ASSERT_NOW(a_refused_full, clock, reset,
      rsp_tvalid && !rsp_tdata[RSP_ACCEPTED_BIT],
      rsp_tdata[RSP_FREE_LSB +: SLOT_W] == '0)
   // An emptied window disarms and never rearms the timer
   `SWAT_ASSERT_NOW(a_emptied_timer, clock, reset,
      rsp_tvalid && rsp_tdata[RSP_EMPTIED_BIT],
      rsp_tdata[RSP_STOP_BIT] && !rsp_tdata[RSP_START_BIT])

endmodule
